// ===== rtl/byte_entropy_estimator_top_assert.svh =====
// Assertion macros for the byte entropy estimator.
`ifndef BYTE_ENTROPY_ESTIMATOR_TOP_ASSERT_SVH
`define BYTE_ENTROPY_ESTIMATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BEE_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BEE_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BEE_ASSERT_IMP(label, clk, rst_n, a, c)
`define BEE_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/bee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_pkg
// Types and constants shared by the byte entropy estimator modules.
// ----------------------------------------------------------------------------
package bee_pkg;
    localparam int COUNT_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int LOG_FRAC       = 24;
    localparam int BINS           = 256;
    localparam int BIN_BITS       = 8;
    localparam int ENT_W          = 20;
    localparam int TOT_W          = 24;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_RUN, ST_RD, ST_SUM, ST_LOGN, ST_DIV, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        LG_IDLE, LG_NORM, LG_SQ, LG_MUL
    } t_lstate;

    // Request and response between the controller and the log unit.
    typedef struct packed {
        logic start;
    } t_log_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_log_rsp;
endpackage

// ===== rtl/bee_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_ram
// Single-port-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bee_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/bee_log2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_log2
// Iterative log2 in Q.24 by leading-one search and repeated squaring, then
// multiplies the result by the argument (x*log2 x) over partial products.
// ----------------------------------------------------------------------------
module bee_log2 #(
    parameter int COUNT_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bee_pkg::t_log_req           i_req,
    input  logic [COUNT_BITS-1:0]       i_x,
    output bee_pkg::t_log_rsp           o_rsp,
    output logic [COUNT_BITS+5+24-1:0]  o_xlog
);
    localparam int LW = 5 + bee_pkg::LOG_FRAC;
    localparam int EW = $clog2(COUNT_BITS);
    localparam int PW = COUNT_BITS + LW;

    bee_pkg::t_lstate r_st, n_st;
    logic [COUNT_BITS-1:0] r_x;
    logic [EW-1:0]         r_e;
    logic [32:0]           r_m;
    logic [4:0]            r_i;
    logic [23:0]           r_frac;
    logic [LW-1:0]         r_l;
    logic [COUNT_BITS-1:0] r_xs;
    logic [65:0]           w_sq;
    logic [32:0]           w_mn;
    logic [COUNT_BITS-1:0] w_sh;

    // Normalize one bit position per cycle.
    assign w_sh = r_x >> (r_e + EW'(1));
    assign w_sq = (66'(r_m) * 66'(r_m)) >> 31;
    assign w_mn = w_sq[32:0];

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            bee_pkg::LG_IDLE: if (i_req.start) n_st = bee_pkg::LG_NORM;
            bee_pkg::LG_NORM: if (w_sh == '0 || 32'(r_e) == COUNT_BITS - 1)
                n_st = bee_pkg::LG_SQ;
            bee_pkg::LG_SQ:   if (r_i == 5'd23) n_st = bee_pkg::LG_MUL;
            bee_pkg::LG_MUL:  if (r_xs == '0) n_st = bee_pkg::LG_IDLE;
            default:          n_st = bee_pkg::LG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bee_pkg::LG_IDLE;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                bee_pkg::LG_IDLE: begin
                    r_x <= i_x;
                    r_e <= '0;
                    r_i <= '0;
                    r_frac <= '0;
                end
                bee_pkg::LG_NORM: begin
                    if (!(w_sh == '0 || 32'(r_e) == COUNT_BITS - 1)) begin
                        r_e <= r_e + EW'(1);
                    end else begin
                        r_m <= 33'({r_x, 31'd0} >> r_e);
                    end
                end
                bee_pkg::LG_SQ: begin
                    r_i <= r_i + 5'd1;
                    if (w_mn[32]) begin
                        r_m <= w_mn >> 1;
                        r_frac <= {r_frac[22:0], 1'b1};
                    end else begin
                        r_m <= w_mn;
                        r_frac <= {r_frac[22:0], 1'b0};
                    end
                    if (r_i == 5'd23) begin
                        r_l <= (r_x <= COUNT_BITS'(1)) ? '0 :
                            {5'(r_e), r_frac[22:0], w_mn[32]};
                        r_xs <= r_x;
                    end
                end
                bee_pkg::LG_MUL: begin
                    // Shift-add multiply, eight multiplier bits per cycle.
                    r_l   <= r_l;
                    r_xs  <= r_xs >> 8;
                end
                default: ;
            endcase
        end
    end

    logic [4:0] r_sh8;
    always_ff @(posedge i_clk) begin
        if (r_st == bee_pkg::LG_SQ) r_sh8 <= '0;
        else if (r_st == bee_pkg::LG_MUL) r_sh8 <= r_sh8 + 5'd8;
    end

    logic [PW-1:0] w_term;
    assign w_term = (PW'(r_l) * PW'(r_xs[7:0])) << r_sh8;
    logic [PW-1:0] r_res;
    always_ff @(posedge i_clk) begin
        if (r_st == bee_pkg::LG_SQ) r_res <= '0;
        else if (r_st == bee_pkg::LG_MUL) r_res <= r_res + w_term;
    end

    assign o_rsp.busy = (r_st != bee_pkg::LG_IDLE);
    assign o_rsp.done = (r_st == bee_pkg::LG_MUL) && (r_xs == '0);
    assign o_xlog = r_res;
endmodule

// ===== rtl/byte_entropy_estimator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_entropy_estimator_top
// 256-bin byte histogram in RAM with Shannon entropy on the last transaction.
// ----------------------------------------------------------------------------
// A byte transaction is a RAM read, then a write back. On last, the reduction
// reads each bin: a bin with a count below two is passed over, any other goes
// to the log unit for x*log2 x; then x*log2 x of the total and the divide
// follow. Each result starts a clearing pass over all 256 bins, as reset does,
// with no transaction accepted.
// Reset is synchronous, active low.
`include "byte_entropy_estimator_top_assert.svh"
module byte_entropy_estimator_top #(
    parameter int COUNT_BITS = bee_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = bee_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [19:0] o_entropy_fixed,
    output logic [23:0] o_byte_total,
    output logic        o_count_overflow
);
    localparam int LW = 5 + bee_pkg::LOG_FRAC;
    localparam int SW = COUNT_BITS + LW + 8;
    localparam int SH = bee_pkg::LOG_FRAC - FRAC_BITS;
    localparam int QW = LW;

    bee_pkg::t_state r_st, n_st;
    logic [bee_pkg::BIN_BITS-1:0] r_addr;
    logic [7:0] r_byte;
    logic       r_pend, r_last, r_has;
    logic [COUNT_BITS-1:0] r_tot;
    logic       r_ovf;
    logic [SW-1:0] r_s, r_t;
    logic [QW-1:0] r_q;
    logic [6:0]    r_dc;
    logic [SW-1:0] r_rem;
    logic [19:0]   r_ent;
    logic [23:0]   r_tout;
    logic          r_oovf;
    logic          r_lstart, n_lstart;

    logic                  w_we;
    logic                  w_load;
    logic [bee_pkg::BIN_BITS-1:0] w_waddr, w_raddr;
    logic [COUNT_BITS-1:0] w_wdata, w_rdata;
    bee_pkg::t_log_req     w_req;
    bee_pkg::t_log_rsp     w_rsp;
    logic [COUNT_BITS+LW-1:0] w_xlog;
    logic [COUNT_BITS-1:0] w_lx;
    logic [SW-1:0]         w_trial;
    logic [QW:0]           w_hr;
    logic [QW-1:0]         w_hq;

    bee_ram #(.WIDTH(COUNT_BITS), .DEPTH(bee_pkg::BINS)) u_hist (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    bee_log2 #(.COUNT_BITS(COUNT_BITS)) u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_x(w_lx),
        .o_rsp(w_rsp), .o_xlog(w_xlog)
    );

    assign o_ready = (r_st == bee_pkg::ST_RUN) && !r_pend;
    assign w_raddr = (r_st == bee_pkg::ST_RUN) ? i_byte_value : r_addr;
    assign w_lx    = (r_st == bee_pkg::ST_LOGN) ? r_tot : w_rdata;
    assign w_req.start = r_lstart;
    assign w_trial = {r_rem[SW-2:0], r_t[SW-1]} - SW'(r_tot);
    // The output register takes a new result once the previous one is gone.
    assign w_load = (r_st == bee_pkg::ST_OUT) && (!o_valid || i_ready);

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        if (r_st == bee_pkg::ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_st == bee_pkg::ST_RUN && r_pend && r_has
                     && r_tot != {COUNT_BITS{1'b1}}) begin
            w_we = 1'b1;
            w_waddr = r_byte;
            w_wdata = w_rdata + COUNT_BITS'(1);
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            bee_pkg::ST_CLEAR: if (r_addr == 8'hFF) n_st = bee_pkg::ST_RUN;
            bee_pkg::ST_RUN:   if (r_pend && r_last) n_st = bee_pkg::ST_RD;
            bee_pkg::ST_RD:    n_st = bee_pkg::ST_SUM;
            bee_pkg::ST_SUM:   if (!w_rsp.busy && !r_lstart && r_addr == 8'hFF
                                   && w_rdata <= COUNT_BITS'(1))
                                   n_st = bee_pkg::ST_LOGN;
                               else if (w_rsp.done && r_addr == 8'hFF)
                                   n_st = bee_pkg::ST_LOGN;
                               else if (w_rsp.done || (!w_rsp.busy && !r_lstart
                                   && w_rdata <= COUNT_BITS'(1)))
                                   n_st = bee_pkg::ST_RD;
            bee_pkg::ST_LOGN:  if (w_rsp.done) n_st = bee_pkg::ST_DIV;
            bee_pkg::ST_DIV:   if (r_dc == 7'(SW - 1)) n_st = bee_pkg::ST_OUT;
            bee_pkg::ST_OUT:   if (w_load) n_st = bee_pkg::ST_CLEAR;
            default:           n_st = bee_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        n_lstart = 1'b0;
        if (r_st == bee_pkg::ST_SUM) begin
            if (!w_rsp.busy && !r_lstart && w_rdata > COUNT_BITS'(1)) n_lstart = 1'b1;
            if (n_st == bee_pkg::ST_LOGN) n_lstart = 1'b1;
        end
    end

    // Quotient rounding and cap.
    assign w_hr = (SH > 0) ? ((QW+1)'(r_q) + (QW+1)'((SH > 0) ? (1 << (SH-1)) : 0))
                             >> SH : (QW+1)'(r_q);
    assign w_hq = (w_hr > (QW+1)'(8 << FRAC_BITS)) ? QW'(8 << FRAC_BITS) : QW'(w_hr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bee_pkg::ST_CLEAR;
            r_addr <= '0;
            r_pend <= 1'b0;
            r_tot <= '0;
            r_ovf <= 1'b0;
            r_lstart <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_lstart <= n_lstart;
            if (w_load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            unique case (r_st)
                bee_pkg::ST_CLEAR: begin
                    r_addr <= r_addr + 8'd1;
                    r_tot <= '0;
                    r_ovf <= 1'b0;
                    r_pend <= 1'b0;
                end
                bee_pkg::ST_RUN: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        if (r_has) begin
                            if (r_tot == {COUNT_BITS{1'b1}}) r_ovf <= 1'b1;
                            else r_tot <= r_tot + COUNT_BITS'(1);
                        end
                        r_addr <= '0;
                        r_s <= '0;
                    end else if (i_valid) begin
                        r_pend <= 1'b1;
                    end
                end
                bee_pkg::ST_RD: ;
                bee_pkg::ST_SUM: begin
                    if (!w_rsp.busy && !r_lstart && w_rdata <= COUNT_BITS'(1)) begin
                        r_addr <= r_addr + 8'd1;
                    end
                    if (w_rsp.done) begin
                        r_s <= r_s + SW'(w_xlog);
                        r_addr <= r_addr + 8'd1;
                    end
                end
                bee_pkg::ST_LOGN: begin
                    if (w_rsp.done) begin
                        r_t <= (SW'(w_xlog) > r_s) ? SW'(w_xlog) - r_s : '0;
                        r_rem <= '0;
                        r_dc <= '0;
                        r_q <= '0;
                    end
                end
                bee_pkg::ST_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    r_dc <= r_dc + 7'd1;
                    r_t <= r_t << 1;
                    if (!w_trial[SW-1] || r_rem[SW-1]) begin
                        r_rem <= w_trial;
                        r_q <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[SW-2:0], r_t[SW-1]};
                        r_q <= {r_q[QW-2:0], 1'b0};
                    end
                end
                bee_pkg::ST_OUT: begin
                    if (w_load) begin
                        r_ent <= (r_tot == '0) ? '0 : 20'(w_hq);
                        r_tout <= 24'(r_tot);
                        r_oovf <= r_ovf;
                        r_addr <= '0;
                    end
                end
                default: ;
            endcase
        end
        if (o_ready && i_valid) begin
            r_byte <= i_byte_value;
            r_has <= i_has_byte;
            r_last <= i_last;
        end
    end

    assign o_entropy_fixed  = r_ent;
    assign o_byte_total     = r_tout;
    assign o_count_overflow = r_oovf;

    `BEE_ASSERT_IMP(a_ready_run, i_clk, i_rst_n, o_ready, r_st == bee_pkg::ST_RUN)
    `BEE_ASSERT_NXT(a_acc_pend, i_clk, i_rst_n, o_ready && i_valid, r_pend)
    `BEE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_entropy_fixed) && $stable(o_byte_total))
endmodule
